// ===== hdl/sha256_pkg.sv =====
`default_nettype none

package sha256_pkg;

  localparam int WordW      = 32;
  localparam int SchedDepth = 16;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        is_last;
  } sha_out_t;

  localparam logic [7:0][31:0] HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sha256_hash_engine.sv =====
`default_nettype none

// Channel  Direction  Payload                                        Handshake
// in       input      sha_in_t  {data_word, byte_count, end_of_message} in_valid_i / in_stall_o
// out      output     sha_out_t {digest_word, is_last}                 out_valid_o / out_stall_i
//
// An item is taken whenever the engine is idle; an item that fills the 16th word of a block
// starts a compression whose rounds each pass the address, gather and schedule phases (set by the
// two-port schedule RAM feeding four schedule words per round), followed by a finish step.
// At message end the padding words (marker, zeros, length) are written, with any compressions they fill;
// then eight digest items follow, one per cycle unless out_stall_i holds them.
// Reset restores the initial hash and clears the length; in_stall_o is high when not idle.

module sha256_hash_engine (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire sha256_pkg::sha_in_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output sha256_pkg::sha_out_t      out_data_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_COMP = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    PS_MARK  = 4'b0001,
    PS_ZERO  = 4'b0010,
    PS_LENHI = 4'b0100,
    PS_LENLO = 4'b1000
  } pad_e;

  typedef enum logic [2:0] {
    PH_ADDR   = 3'b001,
    PH_GATHER = 3'b010,
    PH_SCHED  = 3'b100
  } phase_e;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  state_e state_q, state_d, ret_q, ret_d;
  pad_e   pstage_q, pstage_d;
  phase_e ph_q, ph_d;

  logic [7:0][31:0] hash_q, hash_d;
  logic [7:0][31:0] wv_q, wv_d;
  logic [63:0]      bitlen_q, bitlen_d;
  logic [3:0]       pos_q, pos_d;
  logic [1:0]       slot_q, slot_d;
  logic [31:0]      part_q, part_d;
  logic [6:0]       t_q, t_d;
  logic             pend_q, pend_d;
  logic [2:0]       idx_q, idx_d;
  logic [31:0]      wt_q, wt_d, k_q, k_d, w16_q, w16_d, w15_q, w15_d;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_ra, ram_rb;
  logic [31:0] ram_wdata, ram_rda, ram_rdb;

  logic        in_acc, out_acc;
  logic [2:0]  cnt, total;
  logic [31:0] data_m;
  logic [63:0] comb;

  logic [31:0] s1, ch, t1, s0, maj, sig0, sig1;
  logic [7:0][31:0] wv_rnd;

  sha256_ram #(
    .Width(sha256_pkg::WordW),
    .Depth(sha256_pkg::SchedDepth)
  ) u_sched_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_ra),
    .raddr_b_i(ram_rb),
    .rdata_a_o(ram_rda),
    .rdata_b_o(ram_rdb)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign out_data_o.digest_word = hash_q[idx_q];
  assign out_data_o.is_last     = (idx_q == 3'd7);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // byte packing
  assign cnt    = (in_data_i.byte_count > 3'd4) ? 3'd4 : in_data_i.byte_count;
  assign data_m = in_data_i.data_word & ~(32'hffffffff >> {cnt, 3'b000});
  assign comb   = {part_q, 32'h0} | ({data_m, 32'h0} >> {slot_q, 3'b000});
  assign total  = {1'b0, slot_q} + cnt;

  // round datapath
  assign s1  = ror(wv_q[4], 6) ^ ror(wv_q[4], 11) ^ ror(wv_q[4], 25);
  assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign t1  = wv_q[7] + s1 + ch + k_q + wt_q;
  assign s0  = ror(wv_q[0], 2) ^ ror(wv_q[0], 13) ^ ror(wv_q[0], 22);
  assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);

  assign wv_rnd[7] = wv_q[6];
  assign wv_rnd[6] = wv_q[5];
  assign wv_rnd[5] = wv_q[4];
  assign wv_rnd[4] = wv_q[3] + t1;
  assign wv_rnd[3] = wv_q[2];
  assign wv_rnd[2] = wv_q[1];
  assign wv_rnd[1] = wv_q[0];
  assign wv_rnd[0] = t1 + s0 + maj;

  // schedule expansion: ram_rdb is W[t-2], w15_q is W[t-15]
  assign sig1 = ror(ram_rdb, 17) ^ ror(ram_rdb, 19) ^ (ram_rdb >> 10);
  assign sig0 = ror(w15_q, 7) ^ ror(w15_q, 18) ^ (w15_q >> 3);

  assign ram_ra = (ph_q == PH_ADDR) ? t_q[3:0] : t_q[3:0] + 4'd9;
  assign ram_rb = (ph_q == PH_ADDR) ? t_q[3:0] + 4'd1 : t_q[3:0] + 4'd14;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    pstage_d  = pstage_q;
    ph_d      = ph_q;
    hash_d    = hash_q;
    wv_d      = wv_q;
    bitlen_d  = bitlen_q;
    pos_d     = pos_q;
    slot_d    = slot_q;
    part_d    = part_q;
    t_d       = t_q;
    pend_d    = pend_q;
    idx_d     = idx_q;
    wt_d      = wt_q;
    k_d       = k_q;
    w16_d     = w16_q;
    w15_d     = w15_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = 32'h0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          bitlen_d = bitlen_q + {58'b0, cnt, 3'b000};
          slot_d   = total[1:0];
          if (in_data_i.end_of_message) begin
            pstage_d = PS_MARK;
            state_d  = ST_PAD;
          end
          if (total[2]) begin
            ram_we    = 1'b1;
            ram_wdata = comb[63:32];
            part_d    = comb[31:0];
            pos_d     = pos_q + 4'd1;
            if (pos_q == 4'd15) begin
              wv_d    = hash_q;
              t_d     = '0;
              ph_d    = PH_ADDR;
              pend_d  = 1'b0;
              ret_d   = in_data_i.end_of_message ? ST_PAD : ST_IDLE;
              state_d = ST_COMP;
            end
          end else begin
            part_d = comb[63:32];
          end
        end
      end

      ST_PAD: begin
        ram_we = 1'b1;
        pos_d  = pos_q + 4'd1;
        unique case (pstage_q)
          PS_MARK: begin
            ram_wdata = part_q | (32'h80000000 >> {slot_q, 3'b000});
            part_d    = '0;
            slot_d    = '0;
            pstage_d  = (pos_q == 4'd13) ? PS_LENHI : PS_ZERO;
          end
          PS_ZERO: begin
            ram_wdata = 32'h0;
            pstage_d  = (pos_q == 4'd13) ? PS_LENHI : PS_ZERO;
          end
          PS_LENHI: begin
            ram_wdata = bitlen_q[63:32];
            pstage_d  = PS_LENLO;
          end
          PS_LENLO: begin
            ram_wdata = bitlen_q[31:0];
          end
          default: ;
        endcase
        if (pos_q == 4'd15) begin
          wv_d    = hash_q;
          t_d     = '0;
          ph_d    = PH_ADDR;
          pend_d  = 1'b0;
          ret_d   = (pstage_q == PS_LENLO) ? ST_EMIT : ST_PAD;
          state_d = ST_COMP;
        end
      end

      ST_COMP: begin
        unique case (ph_q)
          PH_ADDR: begin
            if (pend_q) begin
              wv_d = wv_rnd;
            end
            pend_d = 1'b0;
            if (t_q[6]) begin
              state_d = ST_FIN;
            end else begin
              ph_d = PH_GATHER;
            end
          end
          PH_GATHER: begin
            w16_d = ram_rda;
            w15_d = ram_rdb;
            ph_d  = PH_SCHED;
          end
          PH_SCHED: begin
            if (t_q[5:4] == 2'b00) begin
              wt_d = w16_q;
            end else begin
              wt_d      = sig1 + ram_rda + sig0 + w16_q;
              ram_we    = 1'b1;
              ram_waddr = t_q[3:0];
              ram_wdata = wt_d;
            end
            k_d    = sha256_pkg::round_k(t_q[5:0]);
            t_d    = t_q + 7'd1;
            pend_d = 1'b1;
            ph_d   = PH_ADDR;
          end
          default: ph_d = PH_ADDR;
        endcase
      end

      ST_FIN: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + wv_q[i];
        end
        idx_d   = '0;
        state_d = ret_q;
      end

      ST_EMIT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            hash_d   = sha256_pkg::HashInit;
            bitlen_d = '0;
            pos_d    = '0;
            slot_d   = '0;
            part_d   = '0;
            state_d  = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ret_q    <= ST_IDLE;
      pstage_q <= PS_MARK;
      ph_q     <= PH_ADDR;
      hash_q   <= sha256_pkg::HashInit;
      bitlen_q <= '0;
      pos_q    <= '0;
      slot_q   <= '0;
      part_q   <= '0;
      t_q      <= '0;
      pend_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      pstage_q <= pstage_d;
      ph_q     <= ph_d;
      hash_q   <= hash_d;
      bitlen_q <= bitlen_d;
      pos_q    <= pos_d;
      slot_q   <= slot_d;
      part_q   <= part_d;
      t_q      <= t_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q  <= wv_d;
    wt_q  <= wt_d;
    k_q   <= k_d;
    w16_q <= w16_d;
    w15_q <= w15_d;
  end

  a_no_sched_write_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && ph_q == PH_SCHED && t_q[5:4] == 2'b00) |-> !ram_we)
    else $error("schedule RAM written during message rounds");

  a_round_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP && ph_q == PH_ADDR && t_q != '0) |-> pend_q)
    else $error("round result lost");

  a_fin_after_64: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> ($past(state_q) == ST_COMP && $past(t_q) == 7'd64))
    else $error("block finished before 64 rounds");

  a_clean_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.is_last) |=>
      (state_q == ST_IDLE && pos_q == '0 && slot_q == '0 && bitlen_q == '0))
    else $error("engine not cleared after digest");

endmodule

`default_nettype wire

// ===== hdl/sha256_ram.sv =====
`default_nettype none

module sha256_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int Aw = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [Aw-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [Aw-1:0]    raddr_a_i,
  input  wire logic [Aw-1:0]    raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== verif/sha256_hash_engine_chk.sv =====
module sha256_hash_engine_chk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  sha256_pkg::sha_in_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  sha256_pkg::sha_out_t out_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;

  localparam logic [0:7][31:0] HashStart = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] RoundK = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]          hash_st [8];
  logic [31:0]          sched [16];
  logic [63:0]          msg_bits;
  logic [3:0]           word_slot;
  int                   byte_fill;
  logic [31:0]          gather;
  sha256_pkg::sha_out_t digest_q [$];
  int                   fails;
  int                   checked;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void restart();
    for (int i = 0; i < 8; i++) hash_st[i] = HashStart[i];
    msg_bits  = '0;
    word_slot = '0;
    byte_fill = 0;
    gather    = '0;
  endfunction

  function automatic void compress();
    logic [31:0] v [8];
    logic [31:0] w, t1, t2, w2, w15;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        w2  = sched[(t - 2) % 16];
        w15 = sched[(t - 15) % 16];
        w = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + sched[(t - 7) % 16]
          + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + sched[t % 16];
        sched[t % 16] = w;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + w;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    gather = {gather[23:0], b};
    byte_fill++;
    if (byte_fill == 4) begin
      sched[word_slot] = gather;
      gather    = '0;
      byte_fill = 0;
      word_slot = word_slot + 4'd1;
      if (word_slot == 4'd0) compress();
    end
  endfunction

  // pack the item's bytes; at end of message pad, append length, queue digest
  function automatic void absorb(input sha256_pkg::sha_in_t item);
    int                   n;
    logic [63:0]          len;
    sha256_pkg::sha_out_t r;
    n = (item.byte_count > 3'd4) ? 4 : int'(item.byte_count);
    for (int i = 0; i < n; i++) begin
      take_byte(item.data_word[31 - 8 * i -: 8]);
      msg_bits = msg_bits + 64'd8;
    end
    if (!item.end_of_message) return;
    len = msg_bits;
    take_byte(8'h80);
    while (int'(word_slot) * 4 + byte_fill != 56) take_byte(8'h00);
    for (int i = 0; i < 8; i++) take_byte(len[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) begin
      r.digest_word = hash_st[i];
      r.is_last     = (i == 7);
      digest_q.insert(digest_q.size(), r);
    end
    restart();
  endfunction

  initial begin
    fails   = 0;
    checked = 0;
  end

  always @(posedge clk_i) begin
    sha256_pkg::sha_out_t want;
    if (!rst_ni) begin
      restart();
      digest_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) absorb(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          fails++;
          if (fails <= MaxReports)
            $display("%0t: unexpected digest item %h last=%b", $realtime,
                     out_data_i.digest_word, out_data_i.is_last);
        end else begin
          want = digest_q.pop_front();
          checked++;
          if (out_data_i.digest_word !== want.digest_word ||
              out_data_i.is_last !== want.is_last) begin
            fails++;
            if (fails <= MaxReports)
              $display("%0t: digest mismatch: expected %h last=%b, got %h last=%b",
                       $realtime, want.digest_word, want.is_last,
                       out_data_i.digest_word, out_data_i.is_last);
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= digest_q.size();
    checked_o    <= checked;
  end

endmodule

// ===== verif/sha256_hash_engine_tb.sv =====
module sha256_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumItems      = 280;
  localparam int SteadyAfter   = 230;
  localparam int LongHold      = 300;
  localparam int DrainCycles   = 400;
  localparam int WatchdogLimit = 4000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 out_stall = 1'b0;
  sha256_pkg::sha_in_t  in_data   = '0;
  logic                 in_stall;
  logic                 out_valid;
  sha256_pkg::sha_out_t out_data;

  int fail_count;
  int pending;
  int checked;
  bit long_hold_req = 1'b0;
  bit steady        = 1'b0;
  int items_sent    = 0;
  int msgs_sent     = 0;
  int longest_msg   = 0;
  int stuck_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sha256_hash_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  sha256_hash_engine_chk chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WatchdogLimit) begin
      $display("watchdog: no item moved for %0d cycles", stuck_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // digest receiver: short random stalls until steady, one long hold-off once requested and digests appear
  initial begin
    int stall_left;
    bit long_hold_done;
    stall_left     = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req && !long_hold_done && out_valid === 1'b1) begin
        long_hold_done = 1'b1;
        stall_left     = LongHold - 1;
        out_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic offer(input logic [31:0] d, input int cnt, input bit eom);
    sha256_pkg::sha_in_t item;
    int gap;
    item.data_word      = d;
    item.byte_count     = 3'(cnt);
    item.end_of_message = eom;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // body words are mostly full; now and then a short, empty or oversized count
  task automatic send_message(input int nwords);
    int cnt;
    for (int i = 0; i < nwords; i++) begin
      cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 4;
      offer($urandom(), cnt, 1'b0);
    end
    offer($urandom(), $urandom_range(0, 7), 1'b1);
    msgs_sent++;
    if (nwords + 1 > longest_msg) longest_msg = nwords + 1;
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int k;
    int nwords;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message, "abc", oversized count on the final word
    offer(32'hffffffff, 0, 1'b1);
    offer(32'h616263ff, 3, 1'b1);
    offer(32'hffffffff, 7, 1'b1);
    msgs_sent += 3;
    // short and empty words inside a message, oversized counts mid-stream
    offer(32'h12345678, 1, 1'b0);
    offer(32'h9abcdef0, 2, 1'b0);
    offer(32'hdeadbeef, 0, 1'b0);
    offer(32'h0badf00d, 5, 1'b0);
    offer(32'hcafef00d, 6, 1'b0);
    offer(32'h80000001, 3, 1'b1);
    msgs_sent++;
    // 56 bytes: length no longer fits, padding adds a block
    for (int i = 0; i < 14; i++) offer(i[0] ? 32'hffffffff : 32'h00000000, 4, 1'b0);
    offer(32'hffffffff, 0, 1'b1);
    msgs_sent++;
    longest_msg = 15;

    k = 0;
    while (items_sent < NumItems) begin
      if (k == 3) long_hold_req <= 1'b1;
      if (k == 7) wait_for_digests();
      if (items_sent >= SteadyAfter) steady <= 1'b1;
      nwords = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 18);
      send_message(nwords);
      k++;
    end

    wait_for_digests();
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d items in %0d messages (longest %0d words), including empty,",
             items_sent, msgs_sent, longest_msg);
    $display("short and oversized byte counts and padding blocks; %0d digest words checked",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d digest words still expected", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
